[src/gas_sensor_frame_receiver_defines.svh]
// ----------------------------------------------------------------------------
// gas sensor frame receiver assertion macros
// shared property forms for the port-level checker
// ----------------------------------------------------------------------------
`ifndef GAS_SENSOR_FRAME_RECEIVER_DEFINES_SVH
`define GAS_SENSOR_FRAME_RECEIVER_DEFINES_SVH

// same-cycle implication, disabled while the reset argument is low
`define GSFR_ASSERT_NOW(lbl, ck, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while the reset argument is low
`define GSFR_ASSERT_NEXT(lbl, ck, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/gsfr_pkg.sv]
// ----------------------------------------------------------------------------
// gsfr_pkg
// types and constants of the gas sensor frame receiver
// ----------------------------------------------------------------------------
package gsfr_pkg;

  // input transaction kinds
  typedef enum logic [0:0] {
    OP_BYTE = 1'b0,
    OP_TICK = 1'b1
  } op_t;

  // frame layout
  localparam int          FRAME_LEN     = 10;
  localparam logic [3:0]  FRAME_LAST    = 4'd9;
  localparam logic [7:0]  START_FIRST   = 8'h3C;
  localparam logic [7:0]  START_SECOND  = 8'h04;
  localparam logic [7:0]  SUM_SEED      = START_FIRST + START_SECOND;
  localparam logic [7:0]  PREV_AFTER_FR = 8'hFF;

  // configuration registers
  localparam logic [0:0]  REG_TIMEOUT_TICKS = 1'b0;
  localparam logic [15:0] TIMEOUT_RESET     = 16'd100;

  // one result transaction
  typedef struct packed {
    logic        frame_checked;
    logic        checksum_ok;
    logic [15:0] oxygen_raw;
    logic [15:0] carbon_monoxide_raw;
    logic [15:0] hydrogen_sulfide_raw;
    logic [15:0] methane_raw;
    logic [15:0] good_frame_count;
    logic        receiving;
  } res_t;

endpackage

[src/gas_sensor_frame_receiver.sv]
// ----------------------------------------------------------------------------
// gas_sensor_frame_receiver
// hunts for the 0x3C 0x04 start pair, collects ten frame bytes, checks the
// frame sum and latches four gas readings on a good frame
// ----------------------------------------------------------------------------
// usage
//   input channel: one transaction is a received byte (opcode 0) or one time
//   tick (opcode 1); ticks drive the frame timeout
//   result channel: exactly one result transaction per input transaction,
//   carrying the check flags, the latched readings, the good-frame count and
//   the receiving flag as they stand after that input
//   config port: APB-style, timeout_ticks at byte address 0, pready tied high
// throughput
//   one input is taken every cycle while in_ready is high; results enter the
//   result register, or the skid register while out_ready holds it, and the
//   frame sum and state update are combinational ahead of the result register
// stall
//   a two-entry output buffer (result register plus skid register) holds
//   results while out_ready is low; in_ready drops only when both are full
// reset
//   rst_n low clears the frame state, readings, counter and output buffer and
//   restores timeout_ticks to 100
// ----------------------------------------------------------------------------
module gas_sensor_frame_receiver (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [0:0]  in_opcode,
  input  logic [7:0]  in_rx_byte,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_frame_checked,
  output logic        out_checksum_ok,
  output logic [15:0] out_oxygen_raw,
  output logic [15:0] out_carbon_monoxide_raw,
  output logic [15:0] out_hydrogen_sulfide_raw,
  output logic [15:0] out_methane_raw,
  output logic [15:0] out_good_frame_count,
  output logic        out_receiving,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  import gsfr_pkg::*;

  // state
  logic [15:0] timeout_ticks_r;
  logic [7:0]  prev_byte_r,   prev_byte_nxt;
  logic [3:0]  pos_r,         pos_nxt;
  logic        collecting_r,  collecting_nxt;
  logic [7:0]  store_r   [FRAME_LEN];
  logic [7:0]  store_nxt [FRAME_LEN];
  logic [15:0] tmo_cnt_r,     tmo_cnt_nxt;
  logic        timer_run_r,   timer_run_nxt;
  logic [15:0] readings_r   [4];
  logic [15:0] readings_nxt [4];
  logic [15:0] good_cnt_r,    good_cnt_nxt;

  // output buffer
  res_t        out_r, skid_r, res_nxt;
  logic        out_valid_r, skid_valid_r;

  logic        accept, pop, is_byte, byte_wr;
  logic        tenth, timeout, check, sum_ok;
  logic [7:0]  s01, s23, s45, s67, s0_3, s4_7, s8c, sum;

  assign accept  = in_valid && in_ready;
  assign pop     = out_valid_r && out_ready;
  assign is_byte = (op_t'(in_opcode) == OP_BYTE);
  assign byte_wr = accept && is_byte && collecting_r;

  // config port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_TIMEOUT_TICKS) ? {16'd0, timeout_ticks_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_ticks_r <= TIMEOUT_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_TIMEOUT_TICKS)) begin
      timeout_ticks_r <= pwdata[15:0];
    end
  end

  // frame store with the incoming byte written in
  always_comb begin
    for (int k = 0; k < FRAME_LEN; k++) begin
      store_nxt[k] = (byte_wr && (pos_r == 4'(k))) ? in_rx_byte : store_r[k];
    end
  end

  // frame sum over bytes 0 to 8 plus the start pair, as an adder tree
  always_comb begin
    s01  = store_nxt[0] + store_nxt[1];
    s23  = store_nxt[2] + store_nxt[3];
    s45  = store_nxt[4] + store_nxt[5];
    s67  = store_nxt[6] + store_nxt[7];
    s0_3 = s01 + s23;
    s4_7 = s45 + s67;
    s8c  = store_nxt[8] + SUM_SEED;
    sum  = s0_3 + s4_7 + s8c;
  end

  assign tenth   = byte_wr && (pos_r == FRAME_LAST);
  assign timeout = accept && !is_byte && timer_run_r && (tmo_cnt_r <= 16'd1);
  assign check   = tenth || timeout;
  assign sum_ok  = check && (sum == store_nxt[FRAME_LAST]);

  // receiver next state
  always_comb begin
    prev_byte_nxt  = prev_byte_r;
    pos_nxt        = pos_r;
    collecting_nxt = collecting_r;
    tmo_cnt_nxt    = tmo_cnt_r;
    timer_run_nxt  = timer_run_r;
    good_cnt_nxt   = good_cnt_r;
    for (int k = 0; k < 4; k++) begin
      readings_nxt[k] = readings_r[k];
    end

    if (accept) begin
      if (is_byte) begin
        prev_byte_nxt = in_rx_byte;
        if (collecting_r) begin
          pos_nxt = pos_r + 4'd1;
        end else if ((prev_byte_r == START_FIRST) && (in_rx_byte == START_SECOND)) begin
          collecting_nxt = 1'b1;
          pos_nxt        = 4'd0;
          tmo_cnt_nxt    = timeout_ticks_r;
          timer_run_nxt  = 1'b1;
        end
      end else if (timer_run_r && !timeout) begin
        tmo_cnt_nxt = tmo_cnt_r - 16'd1;
      end
    end

    // frame check ends collection
    if (check) begin
      collecting_nxt = 1'b0;
      pos_nxt        = 4'd0;
      timer_run_nxt  = 1'b0;
      tmo_cnt_nxt    = 16'd0;
    end
    if (tenth) begin
      prev_byte_nxt = PREV_AFTER_FR;
    end

    // good frame latches readings big-endian
    if (sum_ok) begin
      for (int k = 0; k < 4; k++) begin
        readings_nxt[k] = {store_nxt[2*k], store_nxt[2*k+1]};
      end
      good_cnt_nxt = good_cnt_r + 16'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_byte_r  <= 8'd0;
      pos_r        <= 4'd0;
      collecting_r <= 1'b0;
      tmo_cnt_r    <= 16'd0;
      timer_run_r  <= 1'b0;
      good_cnt_r   <= 16'd0;
      for (int k = 0; k < FRAME_LEN; k++) begin
        store_r[k] <= 8'd0;
      end
      for (int k = 0; k < 4; k++) begin
        readings_r[k] <= 16'd0;
      end
    end else begin
      prev_byte_r  <= prev_byte_nxt;
      pos_r        <= pos_nxt;
      collecting_r <= collecting_nxt;
      tmo_cnt_r    <= tmo_cnt_nxt;
      timer_run_r  <= timer_run_nxt;
      good_cnt_r   <= good_cnt_nxt;
      for (int k = 0; k < FRAME_LEN; k++) begin
        store_r[k] <= store_nxt[k];
      end
      for (int k = 0; k < 4; k++) begin
        readings_r[k] <= readings_nxt[k];
      end
    end
  end

  // result transaction for this input
  always_comb begin
    res_nxt.frame_checked        = check;
    res_nxt.checksum_ok          = sum_ok;
    res_nxt.oxygen_raw           = readings_nxt[0];
    res_nxt.carbon_monoxide_raw  = readings_nxt[1];
    res_nxt.hydrogen_sulfide_raw = readings_nxt[2];
    res_nxt.methane_raw          = readings_nxt[3];
    res_nxt.good_frame_count     = good_cnt_nxt;
    res_nxt.receiving            = collecting_nxt;
  end

  // output buffer control
  assign in_ready = !skid_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || pop) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= accept;
      end else begin
        out_valid_r  <= accept;
      end
    end else if (accept) begin
      skid_valid_r <= 1'b1;
    end
  end

  // output buffer payload
  always_ff @(posedge clk) begin
    if (!out_valid_r || pop) begin
      if (skid_valid_r) begin
        out_r <= skid_r;
        if (accept) begin
          skid_r <= res_nxt;
        end
      end else if (accept) begin
        out_r <= res_nxt;
      end
    end else if (accept) begin
      skid_r <= res_nxt;
    end
  end

  assign out_valid                = out_valid_r;
  assign out_frame_checked        = out_r.frame_checked;
  assign out_checksum_ok          = out_r.checksum_ok;
  assign out_oxygen_raw           = out_r.oxygen_raw;
  assign out_carbon_monoxide_raw  = out_r.carbon_monoxide_raw;
  assign out_hydrogen_sulfide_raw = out_r.hydrogen_sulfide_raw;
  assign out_methane_raw          = out_r.methane_raw;
  assign out_good_frame_count     = out_r.good_frame_count;
  assign out_receiving            = out_r.receiving;

endmodule

[src/gsfr_checker.sv]
// ----------------------------------------------------------------------------
// gsfr_checker
// port-level checks of the gas sensor frame receiver, bound to the top level
// ----------------------------------------------------------------------------
`include "gas_sensor_frame_receiver_defines.svh"

module gsfr_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_frame_checked,
  input logic        out_checksum_ok,
  input logic [15:0] out_good_frame_count
);

  // a stalled result holds
  `GSFR_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_good_frame_count), "stalled result changed")

  // a good checksum is only reported on a checked frame
  `GSFR_ASSERT_NOW(a_ok_needs_check, clk, rst_n, out_valid && out_checksum_ok, out_frame_checked, "checksum_ok without frame_checked")

  // input back-pressure only with a result waiting
  `GSFR_ASSERT_NOW(a_ready_low_full, clk, rst_n, !in_ready, out_valid, "in_ready low with empty output")

  // reset empties the result buffer
  `GSFR_ASSERT_NEXT(a_reset_empty, clk, 1'b1, !rst_n, !out_valid, "result valid after reset")

endmodule

bind gas_sensor_frame_receiver gsfr_checker u_gsfr_checker (.*);

[test/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// drives received bytes and time ticks into the gas sensor frame receiver,
// mostly as start pairs and frames with random content, plus noise, cut
// frames and ticks; every result is checked field by field against a directed
// expected value or a cycle-free model of the frame hunt, the sum check and the
// reading latch, across several timeout settings written over the config port
// ----------------------------------------------------------------------------
module tb_top;
  import gsfr_pkg::*;

  localparam int         WATCHDOG_LIMIT = 2000;
  localparam int         IDLE_PCT       = 26;
  localparam int         PHASE_ITEMS    = 230;
  localparam int         NUM_PHASES     = 6;
  localparam logic [0:0] REG_UNUSED     = ~REG_TIMEOUT_TICKS;

  typedef enum logic [0:0] {
    ROW_ITEM,
    ROW_CFG
  } row_kind_t;

  typedef enum int {
    BURST_GOOD,
    BURST_BAD_SUM,
    BURST_CUT,
    BURST_NOISE,
    BURST_TICKS
  } burst_t;

  // one row of the directed stimulus table
  typedef struct packed {
    row_kind_t   kind;
    op_t         op;
    logic [7:0]  data;
    logic [0:0]  reg_idx;
    logic [31:0] wdata;
    logic        typed;
    res_t        want;
  } stim_row_t;

  // dut signals
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [0:0]  in_opcode = OP_BYTE;
  logic [7:0]  in_rx_byte = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_frame_checked;
  logic        out_checksum_ok;
  logic [15:0] out_oxygen_raw;
  logic [15:0] out_carbon_monoxide_raw;
  logic [15:0] out_hydrogen_sulfide_raw;
  logic [15:0] out_methane_raw;
  logic [15:0] out_good_frame_count;
  logic        out_receiving;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = 32'h0;
  logic [31:0] prdata;
  logic        pready;

  // receiver model state
  logic [15:0] timeout_cfg;
  logic [7:0]  prev_rx;
  int          fill_pos;
  logic        in_frame;
  logic [7:0]  frame_bytes [FRAME_LEN];
  logic [15:0] ticks_left;
  logic        timer_on;
  logic [15:0] gas [4];
  logic [15:0] good_count;

  // bench bookkeeping
  res_t        pending_results [$];
  stim_row_t   stim_rows [$];
  int          error_count = 0;
  int          live_items = 0;
  int          quiet_cycles = 0;
  logic        calm = 1'b0;

  gas_sensor_frame_receiver u_dut (
    .clk                      (clk),
    .rst_n                    (rst_n),
    .in_valid                 (in_valid),
    .in_ready                 (in_ready),
    .in_opcode                (in_opcode),
    .in_rx_byte               (in_rx_byte),
    .out_valid                (out_valid),
    .out_ready                (out_ready),
    .out_frame_checked        (out_frame_checked),
    .out_checksum_ok          (out_checksum_ok),
    .out_oxygen_raw           (out_oxygen_raw),
    .out_carbon_monoxide_raw  (out_carbon_monoxide_raw),
    .out_hydrogen_sulfide_raw (out_hydrogen_sulfide_raw),
    .out_methane_raw          (out_methane_raw),
    .out_good_frame_count     (out_good_frame_count),
    .out_receiving            (out_receiving),
    .psel                     (psel),
    .penable                  (penable),
    .pwrite                   (pwrite),
    .paddr                    (paddr),
    .pwdata                   (pwdata),
    .prdata                   (prdata),
    .pready                   (pready)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // one line per mismatch
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("tb_top: mismatch on %s: got %h, expected %h", what, got, want);
    error_count++;
  endtask

  task automatic check_field(input string what, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  function automatic res_t mk_res(input logic chk, input logic ok,
                                  input logic [15:0] o2, input logic [15:0] co,
                                  input logic [15:0] h2s, input logic [15:0] ch4,
                                  input logic [15:0] cnt, input logic rcv);
    res_t r;
    r.frame_checked        = chk;
    r.checksum_ok          = ok;
    r.oxygen_raw           = o2;
    r.carbon_monoxide_raw  = co;
    r.hydrogen_sulfide_raw = h2s;
    r.methane_raw          = ch4;
    r.good_frame_count     = cnt;
    r.receiving            = rcv;
    return r;
  endfunction

  // sum check over the store as it stands; latches readings on a match
  function automatic logic judge_frame();
    logic [7:0] sum;
    sum = SUM_SEED;
    for (int k = 0; k < FRAME_LEN - 1; k++) sum += frame_bytes[k];
    in_frame   = 1'b0;
    fill_pos   = 0;
    timer_on   = 1'b0;
    ticks_left = 16'd0;
    if (sum != frame_bytes[FRAME_LAST]) return 1'b0;
    for (int k = 0; k < 4; k++) gas[k] = {frame_bytes[2*k], frame_bytes[2*k+1]};
    good_count++;
    return 1'b1;
  endfunction

  // advances the receiver model by one transaction
  function automatic res_t step_receiver(input op_t op, input logic [7:0] data);
    logic chk;
    logic ok;
    chk = 1'b0;
    ok  = 1'b0;
    if (op == OP_BYTE) begin
      if (in_frame) begin
        frame_bytes[fill_pos] = data;
        fill_pos++;
        prev_rx = data;
        if (fill_pos == FRAME_LEN) begin
          chk = 1'b1;
          ok  = judge_frame();
          // the tenth byte cannot open a new start pair
          prev_rx = PREV_AFTER_FR;
        end
      end else begin
        if (prev_rx == START_FIRST && data == START_SECOND) begin
          in_frame   = 1'b1;
          fill_pos   = 0;
          ticks_left = timeout_cfg;
          timer_on   = 1'b1;
        end
        prev_rx = data;
      end
    end else if (timer_on) begin
      // a zero timeout fires on the first tick like a timeout of one
      if (ticks_left <= 16'd1) begin
        chk = 1'b1;
        ok  = judge_frame();
      end else begin
        ticks_left--;
      end
    end
    return mk_res(chk, ok, gas[0], gas[1], gas[2], gas[3], good_count, in_frame);
  endfunction

  // send one input transaction, with random idle cycles ahead of it
  task automatic send_item(input op_t op, input logic [7:0] data, input logic typed,
                           input res_t want);
    res_t model_res;
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_opcode  <= op;
    in_rx_byte <= data;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (op == OP_BYTE || timer_on) live_items++;
    model_res = step_receiver(op, data);
    pending_results.push_back(typed ? want : model_res);
  endtask

  // hold off the sender until every pending result is out
  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // apb write while idle, then read the timeout register back
  task automatic write_register(input logic [0:0] idx, input logic [31:0] value);
    wait_for_results();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (idx == REG_TIMEOUT_TICKS) timeout_cfg = value[15:0];
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {REG_TIMEOUT_TICKS, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    check_field("timeout_ticks readback", prdata, {16'h0000, timeout_cfg});
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic add_item(input op_t op, input logic [7:0] data, input logic typed,
                          input res_t want);
    stim_row_t row;
    row         = '0;
    row.kind    = ROW_ITEM;
    row.op      = op;
    row.data    = data;
    row.typed   = typed;
    row.want    = want;
    stim_rows.push_back(row);
  endtask

  task automatic add_cfg(input logic [0:0] idx, input logic [31:0] value);
    stim_row_t row;
    row         = '0;
    row.kind    = ROW_CFG;
    row.reg_idx = idx;
    row.wdata   = value;
    stim_rows.push_back(row);
  endtask

  // result side: random stalls, compare against the oldest expectation
  always @(posedge clk) begin : result_check
    res_t want;
    out_ready <= calm ? 1'b1 : ($urandom_range(99) >= IDLE_PCT);
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending", 32'h0, 32'h0);
      end else begin
        want = pending_results.pop_front();
        check_field("frame_checked", out_frame_checked, want.frame_checked);
        check_field("checksum_ok", out_checksum_ok, want.checksum_ok);
        check_field("oxygen_raw", out_oxygen_raw, want.oxygen_raw);
        check_field("carbon_monoxide_raw", out_carbon_monoxide_raw,
                    want.carbon_monoxide_raw);
        check_field("hydrogen_sulfide_raw", out_hydrogen_sulfide_raw,
                    want.hydrogen_sulfide_raw);
        check_field("methane_raw", out_methane_raw, want.methane_raw);
        check_field("good_frame_count", out_good_frame_count, want.good_frame_count);
        check_field("receiving", out_receiving, want.receiving);
      end
    end
  end

  // watchdog on cycles with no transaction on any port
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || psel || !rst_n) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    stim_row_t  row;
    burst_t     kind;
    logic [7:0] data;
    logic [7:0] sum;
    int         pick;
    int         count;
    int         phase_end;

    // model state after reset
    timeout_cfg = TIMEOUT_RESET;
    prev_rx     = 8'h00;
    fill_pos    = 0;
    in_frame    = 1'b0;
    ticks_left  = 16'd0;
    timer_on    = 1'b0;
    good_count  = 16'd0;
    for (int k = 0; k < FRAME_LEN; k++) frame_bytes[k] = 8'h00;
    for (int k = 0; k < 4; k++) gas[k] = 16'h0000;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // tick while idle, then a start pair, straight out of reset
    add_item(OP_TICK, 8'hFF, 1'b1,
             mk_res(1'b0, 1'b0, 16'h0, 16'h0, 16'h0, 16'h0, 16'd0, 1'b0));
    add_item(OP_BYTE, START_FIRST, 1'b1,
             mk_res(1'b0, 1'b0, 16'h0, 16'h0, 16'h0, 16'h0, 16'd0, 1'b0));
    add_item(OP_BYTE, START_SECOND, 1'b1,
             mk_res(1'b0, 1'b0, 16'h0, 16'h0, 16'h0, 16'h0, 16'd0, 1'b1));
    // good frame at the field extremes, its sum byte equals the first start byte
    for (int k = 0; k < FRAME_LEN - 1; k++)
      add_item(OP_BYTE, (k < 8 && k % 4 < 2) ? 8'hFF : 8'h00, 1'b0, '0);
    add_item(OP_BYTE, 8'h3C, 1'b1,
             mk_res(1'b1, 1'b1, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 16'd1, 1'b0));
    // the tenth byte cannot pair with a following second start byte
    add_item(OP_BYTE, START_SECOND, 1'b0, '0);
    // unmapped register write, then zero timeout
    add_cfg(REG_UNUSED, 32'h0000_0005);
    add_cfg(REG_TIMEOUT_TICKS, 32'h0000_0000);
    // start pair inside a frame is data; timeout checks stale store bytes
    add_item(OP_BYTE, START_FIRST, 1'b0, '0);
    add_item(OP_BYTE, START_SECOND, 1'b0, '0);
    add_item(OP_BYTE, START_FIRST, 1'b0, '0);
    add_item(OP_BYTE, START_SECOND, 1'b0, '0);
    add_item(OP_TICK, 8'h00, 1'b0, '0);
    add_item(OP_TICK, 8'h5A, 1'b0, '0);
    // largest timeout, ticks just count down
    add_cfg(REG_TIMEOUT_TICKS, 32'h0000_FFFF);
    add_item(OP_BYTE, START_FIRST, 1'b0, '0);
    add_item(OP_BYTE, START_SECOND, 1'b0, '0);
    add_item(OP_TICK, 8'h00, 1'b0, '0);
    add_item(OP_TICK, 8'hFF, 1'b0, '0);
    add_item(OP_BYTE, 8'h80, 1'b0, '0);

    foreach (stim_rows[i]) begin
      row = stim_rows[i];
      if (row.kind == ROW_CFG) write_register(row.reg_idx, row.wdata);
      else send_item(row.op, row.data, row.typed, row.want);
    end

    // random phases, one timeout setting each
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        0:       write_register(REG_TIMEOUT_TICKS, 32'd1);
        1:       write_register(REG_TIMEOUT_TICKS, 32'h0000_FFFF);
        2:       write_register(REG_TIMEOUT_TICKS, $urandom_range(2, 12));
        3:       write_register(REG_TIMEOUT_TICKS, TIMEOUT_RESET);
        4:       write_register(REG_TIMEOUT_TICKS, $urandom_range(1, 65535));
        default: write_register(REG_TIMEOUT_TICKS, $urandom_range(13, 60));
      endcase
      // one whole phase with no idling on either side
      calm = (phase == 1);
      phase_end = live_items + PHASE_ITEMS;
      while (live_items < phase_end) begin
        pick = $urandom_range(99);
        if (pick < 45)      kind = BURST_GOOD;
        else if (pick < 60) kind = BURST_BAD_SUM;
        else if (pick < 75) kind = BURST_CUT;
        else if (pick < 90) kind = BURST_NOISE;
        else                kind = BURST_TICKS;
        case (kind)
          // start pair and a full frame, with the odd tick in between
          BURST_GOOD, BURST_BAD_SUM: begin
            sum = SUM_SEED;
            send_item(OP_BYTE, START_FIRST, 1'b0, '0);
            send_item(OP_BYTE, START_SECOND, 1'b0, '0);
            for (int k = 0; k < FRAME_LEN - 1; k++) begin
              if ($urandom_range(99) < 8)
                send_item(OP_TICK, 8'($urandom_range(255)), 1'b0, '0);
              data = 8'($urandom_range(255));
              sum += data;
              send_item(OP_BYTE, data, 1'b0, '0);
            end
            if (kind == BURST_BAD_SUM) sum += 8'($urandom_range(1, 255));
            send_item(OP_BYTE, sum, 1'b0, '0);
          end
          // start pair, a few bytes, then ticks toward the timeout
          BURST_CUT: begin
            send_item(OP_BYTE, START_FIRST, 1'b0, '0);
            send_item(OP_BYTE, START_SECOND, 1'b0, '0);
            count = $urandom_range(0, FRAME_LEN - 1);
            for (int k = 0; k < count; k++)
              send_item(OP_BYTE, 8'($urandom_range(255)), 1'b0, '0);
            count = (timeout_cfg <= 16'd40) ? $urandom_range(timeout_cfg + 2)
                                            : $urandom_range(1, 6);
            for (int k = 0; k < count; k++)
              send_item(OP_TICK, 8'($urandom_range(255)), 1'b0, '0);
          end
          // loose bytes, biased toward the start pair values
          BURST_NOISE: begin
            count = $urandom_range(1, 8);
            for (int k = 0; k < count; k++) begin
              case ($urandom_range(3))
                0:       data = START_FIRST;
                1:       data = START_SECOND;
                default: data = 8'($urandom_range(255));
              endcase
              send_item(OP_BYTE, data, 1'b0, '0);
            end
          end
          default: begin
            count = $urandom_range(1, 4);
            for (int k = 0; k < count; k++)
              send_item(OP_TICK, 8'($urandom_range(255)), 1'b0, '0);
          end
        endcase
        // now and then the sender waits for the result side to drain
        if ($urandom_range(99) < 3) wait_for_results();
      end
      calm = 1'b0;
    end

    wait_for_results();
    repeat (4) @(posedge clk);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
